/* sv/assert_macros.svh */
// assertion macros shared by the heap sift-down rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define HSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define HSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/hsd_pkg.sv */
// types, constants and microcode table of the heap sift-down unit
package hsd_pkg;

	localparam int HSD_KIND_W     = 2;
	localparam int HSD_IDX_W      = 10;
	localparam int HSD_KID_W      = HSD_IDX_W + 1;
	localparam int HSD_DATA_W     = 32;
	localparam int HSD_HEAP_DEPTH = 1024;

	typedef enum logic [HSD_KIND_W-1:0] {
		K_WRITE = 2'd0,
		K_SIFT  = 2'd1,
		K_READ  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0,
		ST_DISP = 4'd1,
		ST_WR   = 4'd2,
		ST_RD   = 4'd3,
		ST_NOP  = 4'd4,
		ST_SCHK = 4'd5,
		ST_PICK = 4'd6,
		ST_MOVE = 4'd7,
		ST_FIN  = 4'd8,
		ST_RESP = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_IF,
		J_WAIT,
		J_KIND
	} jmode_t;

	typedef enum logic [1:0] {
		C_REQ,
		C_OUT_TAKEN,
		C_NOSIFT,
		C_CONT
	} cond_t;

	typedef enum logic [1:0] {
		R_START,
		R_KID_START,
		R_KID_J
	} rsel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_WRITE,
		OP_READ,
		OP_INIT,
		OP_PICK,
		OP_MOVE,
		OP_FIN
	} op_t;

	typedef struct packed {
		logic   in_ready;
		logic   out_valid;
		jmode_t jmode;
		cond_t  cond;
		step_t  target;
		rsel_t  rsel;
		op_t    op;
	} ctl_t;

	function automatic ctl_t ucode(step_t s);
		ctl_t c;
		c = '0;
		c.jmode  = J_GOTO;
		c.cond   = C_REQ;
		c.target = ST_IDLE;
		c.rsel   = R_START;
		c.op     = OP_NONE;
		case (s)
			ST_IDLE: begin
				c.in_ready = 1'b1;
				c.jmode    = J_WAIT;
				c.cond     = C_REQ;
				c.target   = ST_DISP;
				c.op       = OP_LATCH;
			end
			ST_DISP: begin
				c.jmode = J_KIND;
				c.rsel  = R_START;
				c.op    = OP_CLEAR;
			end
			ST_WR: begin
				c.target = ST_RESP;
				c.op     = OP_WRITE;
			end
			ST_RD: begin
				c.target = ST_RESP;
				c.op     = OP_READ;
			end
			ST_NOP: begin
				c.target = ST_RESP;
			end
			ST_SCHK: begin
				c.jmode  = J_IF;
				c.cond   = C_NOSIFT;
				c.target = ST_RESP;
				c.rsel   = R_KID_START;
				c.op     = OP_INIT;
			end
			ST_PICK: begin
				c.jmode = J_NEXT;
				c.op    = OP_PICK;
			end
			ST_MOVE: begin
				c.jmode  = J_IF;
				c.cond   = C_CONT;
				c.target = ST_PICK;
				c.rsel   = R_KID_J;
				c.op     = OP_MOVE;
			end
			ST_FIN: begin
				c.target = ST_RESP;
				c.op     = OP_FIN;
			end
			ST_RESP: begin
				c.out_valid = 1'b1;
				c.jmode     = J_WAIT;
				c.cond      = C_OUT_TAKEN;
				c.target    = ST_IDLE;
			end
			default: begin
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

/* sv/hsd_if.sv */
// request and response channel interfaces of the heap sift-down unit
interface hsd_req_if import hsd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [HSD_KIND_W-1:0]        kind;
	logic [HSD_IDX_W-1:0]         start_index;
	logic [HSD_IDX_W-1:0]         last_index;
	logic signed [HSD_DATA_W-1:0] value;

	modport source (output valid, kind, start_index, last_index, value, input ready);
	modport sink (input valid, kind, start_index, last_index, value, output ready);
endinterface

interface hsd_rsp_if import hsd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [HSD_DATA_W-1:0] read_value;
	logic [HSD_IDX_W-1:0]         final_position;

	modport source (output valid, read_value, final_position, input ready);
	modport sink (input valid, read_value, final_position, output ready);
endinterface

/* sv/heap_sift_down_unit.sv */
// heap sift-down unit: microcoded sequencer over a two-read-port heap ram
// write and read requests: dispatch, then the write or read step, then the response is offered
// sift: dispatch and start check lead to the response if the start has no child in the heap, else
// pick and move repeat per child pair compared, then fin; pairs: levels moved, plus one when a child stops the descent
// one request in flight; the next is taken the cycle after the response leaves
// reset returns the sequencer to idle; heap contents are undefined until written
`include "assert_macros.svh"

module heap_sift_down_unit import hsd_pkg::*; #(
	parameter int HEAP_DEPTH = HSD_HEAP_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	hsd_req_if.sink   req,
	hsd_rsp_if.source rsp
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam logic [HSD_KID_W-1:0] LastCap = HSD_KID_W'(HEAP_DEPTH - 1);

	step_t                   step_q;
	step_t                   step_nxt;
	ctl_t                    ctl;
	logic                    cond_ok;

	logic [HSD_KIND_W-1:0]   kind_q;
	logic [HSD_IDX_W-1:0]    start_q;
	logic [HSD_KID_W-1:0]    last_q;
	logic [HSD_DATA_W-1:0]   value_q;
	logic [HSD_KID_W-1:0]    i_q;
	logic [HSD_KID_W-1:0]    j_q;
	logic [HSD_DATA_W-1:0]   held_q;
	logic [HSD_DATA_W-1:0]   cval_q;
	logic [HSD_DATA_W-1:0]   rdv_q;
	logic [HSD_IDX_W-1:0]    pos_q;

	logic                    start_ok;
	logic [HSD_KID_W-1:0]    kid_start;
	logic [HSD_KID_W-1:0]    kid_j;
	logic                    nosift;
	logic                    stop;
	logic                    leaf;
	logic                    take_right;
	logic [HSD_KID_W-1:0]    rbase;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [HSD_DATA_W-1:0]   ram_wdata;
	logic [HSD_DATA_W-1:0]   rdata_a;
	logic [HSD_DATA_W-1:0]   rdata_b;

	assign ctl = ucode(step_q);

	assign start_ok   = 32'(start_q) < HEAP_DEPTH;
	assign kid_start  = {start_q, 1'b1};
	assign kid_j      = {j_q[HSD_IDX_W-1:0], 1'b1};
	assign nosift     = !start_ok || (kid_start > last_q);
	assign stop       = !($signed(cval_q) > $signed(held_q));
	assign leaf       = kid_j > last_q;
	assign take_right = (j_q < last_q) && ($signed(rdata_b) > $signed(rdata_a));

	always_comb begin
		case (ctl.rsel)
			R_START:     rbase = {1'b0, start_q};
			R_KID_START: rbase = kid_start;
			R_KID_J:     rbase = kid_j;
			default:     rbase = {1'b0, start_q};
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(i_q);
		ram_wdata = held_q;
		case (ctl.op)
			OP_WRITE: begin
				ram_we    = start_ok;
				ram_waddr = AW'(start_q);
				ram_wdata = value_q;
			end
			OP_MOVE: begin
				ram_we    = !stop;
				ram_wdata = cval_q;
			end
			OP_FIN: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	hsd_ram #(
		.WIDTH (HSD_DATA_W),
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (AW'(rbase)),
		.raddr_b (AW'(HSD_KID_W'(rbase + 1'b1))),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// sequencer
	always_comb begin
		case (ctl.cond)
			C_REQ:       cond_ok = req.valid;
			C_OUT_TAKEN: cond_ok = rsp.ready;
			C_NOSIFT:    cond_ok = nosift;
			C_CONT:      cond_ok = !stop && !leaf;
			default:     cond_ok = 1'b0;
		endcase
		case (ctl.jmode)
			J_NEXT: step_nxt = step_t'(step_q + 4'd1);
			J_GOTO: step_nxt = ctl.target;
			J_IF:   step_nxt = cond_ok ? ctl.target : step_t'(step_q + 4'd1);
			J_WAIT: step_nxt = cond_ok ? ctl.target : step_q;
			J_KIND: begin
				case (kind_q)
					K_WRITE: step_nxt = ST_WR;
					K_SIFT:  step_nxt = ST_SCHK;
					K_READ:  step_nxt = ST_RD;
					default: step_nxt = ST_NOP;
				endcase
			end
			default: step_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				if (req.valid) begin
					kind_q  <= req.kind;
					start_q <= req.start_index;
					value_q <= req.value;
					if (32'(req.last_index) > HEAP_DEPTH - 1) begin
						last_q <= LastCap;
					end else begin
						last_q <= {1'b0, req.last_index};
					end
				end
			end
			OP_CLEAR: begin
				rdv_q <= '0;
				pos_q <= '0;
			end
			OP_READ: begin
				if (start_ok) begin
					rdv_q <= rdata_a;
				end
			end
			OP_INIT: begin
				held_q <= rdata_a;
				i_q    <= {1'b0, start_q};
				j_q    <= kid_start;
				pos_q  <= start_q;
			end
			OP_PICK: begin
				cval_q <= take_right ? rdata_b : rdata_a;
				j_q    <= take_right ? HSD_KID_W'(j_q + 1'b1) : j_q;
			end
			OP_MOVE: begin
				if (!stop) begin
					i_q <= j_q;
					j_q <= kid_j;
				end
			end
			OP_FIN: begin
				pos_q <= i_q[HSD_IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign req.ready          = ctl.in_ready;
	assign rsp.valid          = ctl.out_valid;
	assign rsp.read_value     = rdv_q;
	assign rsp.final_position = pos_q;

	`HSD_ASSERT_ALWAYS(a_one_side, !(req.ready && rsp.valid), "request and response sides open together")
	`HSD_ASSERT(a_dispatch, (req.valid && req.ready) |=> (step_q == ST_DISP), "taken request not dispatched")
	`HSD_ASSERT(a_descend, (step_q == ST_MOVE) |-> (j_q > i_q), "child index not below parent")
	`HSD_ASSERT(a_pos_down, (rsp.valid && (kind_q == K_SIFT)) |-> (pos_q >= start_q), "sift ended above start")

endmodule

/* sv/hsd_ram.sv */
// generic ram, one write port and two registered read ports
module hsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* tb/sv/heap_sift_down_unit_test.sv */
// self-checking testbench of the heap sift-down unit: scoreboard class, request driver, response monitor
module heap_sift_down_unit_test import hsd_pkg::*; ();

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [HSD_KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [HSD_KIND_W-1:0]        kind;
		logic [HSD_IDX_W-1:0]         start_index;
		logic [HSD_IDX_W-1:0]         last_index;
		logic signed [HSD_DATA_W-1:0] value;
	} heap_req_t;

	typedef struct {
		logic signed [HSD_DATA_W-1:0] read_value;
		logic [HSD_IDX_W-1:0]         final_position;
	} heap_rsp_t;

	class heap_mirror_sb;
		logic signed [HSD_DATA_W-1:0] heap_mirror [HSD_HEAP_DEPTH];
		bit                           written [HSD_HEAP_DEPTH];
		heap_rsp_t                    pending_responses [$];
		int                           failures;
		int                           checked;
		int                           deepest_sift;
		int                           kind_count [4];

		// true when every word the sift would read has been written
		function bit sift_path_written(int start, int last);
			int i;
			int j;
			logic signed [HSD_DATA_W-1:0] held;
			if (!written[start])
				return 0;
			held = heap_mirror[start];
			i = start;
			j = 2 * i + 1;
			while (j <= last) begin
				if (!written[j] || (j < last && !written[j+1]))
					return 0;
				if (j < last && heap_mirror[j+1] > heap_mirror[j])
					j++;
				if (heap_mirror[j] > held) begin
					i = j;
					j = 2 * i + 1;
				end else begin
					break;
				end
			end
			return 1;
		endfunction

		function bit can_issue(heap_req_t r);
			case (r.kind)
				K_READ: return written[r.start_index];
				K_SIFT: return sift_path_written(r.start_index, r.last_index);
				default: return 1;
			endcase
		endfunction

		function int sift_down(int start, int last);
			int i;
			int j;
			int levels;
			logic signed [HSD_DATA_W-1:0] held;
			held = heap_mirror[start];
			i = start;
			j = 2 * i + 1;
			levels = 0;
			while (j <= last) begin
				if (j < last && heap_mirror[j+1] > heap_mirror[j])
					j++;
				if (heap_mirror[j] > held) begin
					heap_mirror[i] = heap_mirror[j];
					i = j;
					j = 2 * i + 1;
					levels++;
				end else begin
					break;
				end
			end
			heap_mirror[i] = held;
			if (levels > deepest_sift)
				deepest_sift = levels;
			return i;
		endfunction

		function void note_request(heap_req_t r);
			heap_rsp_t e;
			e.read_value = '0;
			e.final_position = '0;
			kind_count[r.kind]++;
			case (r.kind)
				K_WRITE: begin
					heap_mirror[r.start_index] = r.value;
					written[r.start_index] = 1'b1;
				end
				K_SIFT: e.final_position = HSD_IDX_W'(sift_down(r.start_index, r.last_index));
				K_READ: e.read_value = heap_mirror[r.start_index];
				default: ;
			endcase
			pending_responses.push_back(e);
		endfunction

		function void check_response(logic signed [HSD_DATA_W-1:0] rv, logic [HSD_IDX_W-1:0] fp);
			heap_rsp_t e;
			if (pending_responses.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response: read_value %0d final_position %0d", rv, fp);
				return;
			end
			e = pending_responses.pop_front();
			checked++;
			if (rv !== e.read_value || fp !== e.final_position) begin
				failures++;
				if (failures <= 10)
					$display("mismatch on response %0d: expected read_value %0d final_position %0d, got read_value %0d final_position %0d",
						checked, e.read_value, e.final_position, rv, fp);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hsd_req_if req ();
	hsd_rsp_if rsp ();

	heap_sift_down_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	heap_mirror_sb sb;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off_left;
	int sent;
	int cycle_count;
	int stall_run;
	int longest_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_response(rsp.read_value, rsp.final_position);
		if (req.valid === 1'b1 && req.ready !== 1'b1)
			stall_run++;
		else
			stall_run = 0;
		if (stall_run > longest_stall)
			longest_stall = stall_run;
	end

	function automatic heap_req_t mk_req(logic [HSD_KIND_W-1:0] k, int s, int l,
			logic signed [HSD_DATA_W-1:0] v);
		heap_req_t r;
		r.kind = k;
		r.start_index = HSD_IDX_W'(s);
		r.last_index = HSD_IDX_W'(l);
		r.value = v;
		return r;
	endfunction

	function automatic logic signed [HSD_DATA_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return {1'b1, {(HSD_DATA_W-1){1'b0}}};
			1: return {1'b0, {(HSD_DATA_W-1){1'b1}}};
			2, 3: return HSD_DATA_W'(int'($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_written(int lo, int hi);
		int idx;
		for (int t = 0; t < 32; t++) begin
			idx = $urandom_range(hi, lo);
			if (sb.written[idx])
				return idx;
		end
		return 0;
	endfunction

	task automatic send_request(heap_req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= r.kind;
		req.start_index <= r.start_index;
		req.last_index <= r.last_index;
		req.value <= r.value;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(r);
		if (r.kind != KIND_UNUSED)
			sent++;
		@(negedge clk);
	endtask

	// requests that would read a never-written word are dropped
	task automatic issue(heap_req_t r);
		if (sb.can_issue(r))
			send_request(r);
	endtask

	task automatic wr(int idx, logic signed [HSD_DATA_W-1:0] v);
		issue(mk_req(K_WRITE, idx, $urandom_range(1023), v));
	endtask

	task automatic rd(int idx);
		issue(mk_req(K_READ, idx, $urandom_range(1023), $urandom));
	endtask

	task automatic sf(int s, int l);
		issue(mk_req(K_SIFT, s, l, $urandom));
	endtask

	task automatic nop(int s, int l, logic signed [HSD_DATA_W-1:0] v);
		issue(mk_req(KIND_UNUSED, s, l, v));
	endtask

	task automatic directed_checks();
		wr(0, 32'sh7fffffff);
		wr(1023, 32'sh80000000);
		rd(0);
		rd(1023);
		wr(1, -1);
		wr(2, 0);
		sf(1023, 1023);
		sf(0, 0);
		// start after last
		sf(2, 1);
		// equal children, left one wins
		wr(0, 5);
		wr(1, 7);
		wr(2, 7);
		sf(0, 2);
		// child equal to held value stays put
		sf(0, 2);
		rd(0);
		rd(1);
		rd(2);
		wr(3, 32'sh7fffffff);
		sf(1, 3);
		rd(1);
		rd(3);
		wr(600, 32'sh80000001);
		sf(600, 1023);
		nop(1023, 1023, -1);
		nop(0, 0, 0);
	endtask

	// fill 0..n-1, heapify, then replace the root a few times
	task automatic build_region();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 2);
		for (int i = 0; i < n; i++)
			wr(i, rand_word());
		for (int i = n / 2 - 1; i >= 0; i--)
			sf(i, n - 1);
		repeat (3)
			rd(pick_written(0, n - 1));
		repeat ($urandom_range(4, 1)) begin
			wr(0, rand_word());
			sf(0, n - 1);
			rd(0);
		end
	endtask

	// one descending path from the root with siblings no larger, then sift a mostly low root down it
	task automatic deep_path();
		int i;
		int c;
		int sib;
		int pv;
		int sv;
		logic signed [HSD_DATA_W-1:0] held;
		pv = $urandom_range(32'h3fffffff);
		if ($urandom_range(9) < 7)
			held = $signed(32'h80000000 + $urandom_range(100));
		else
			held = rand_word();
		wr(0, held);
		i = 0;
		while (2 * i + 2 <= HSD_HEAP_DEPTH - 1) begin
			c = 2 * i + 1 + $urandom_range(1);
			sib = (c % 2 == 1) ? c + 1 : c - 1;
			pv = pv - int'($urandom_range(1000));
			if (c % 2 == 1 && $urandom_range(3) == 0)
				sv = pv;
			else
				sv = pv - int'($urandom_range(1000, 1));
			wr(c, pv);
			wr(sib, sv);
			i = c;
		end
		sf(0, ($urandom_range(4) == 0) ? $urandom_range(1023) : 1023);
		rd(0);
		rd(i);
	endtask

	task automatic noise_item();
		int s;
		int l;
		bit found;
		case ($urandom_range(9))
			0, 1, 2: wr($urandom_range(1023), rand_word());
			3, 4: rd(pick_written(0, 1023));
			5, 6, 7: begin
				found = 1'b0;
				for (int t = 0; t < 20 && !found; t++) begin
					if ($urandom_range(1)) begin
						s = $urandom_range(1023);
						l = $urandom_range(1023);
					end else begin
						s = $urandom_range(63);
						l = $urandom_range(127);
					end
					found = sb.can_issue(mk_req(K_SIFT, s, l, 0));
				end
				if (found)
					sf(s, l);
				else
					sf(pick_written(0, 1023), 0);
			end
			8: nop($urandom_range(1023), $urandom_range(1023), $urandom);
			default: begin
				s = pick_written(1, 1023);
				sf(s, $urandom_range(s - 1));
			end
		endcase
	endtask

	task automatic run_random(int quota);
		int target;
		target = sent + quota;
		while (sent < target) begin
			case ($urandom_range(9))
				0, 1, 2: build_region();
				3, 4: deep_path();
				default: repeat ($urandom_range(5, 1)) noise_item();
			endcase
		end
	endtask

	initial begin
		sb = new();
		req.valid = 1'b0;
		req.kind = '0;
		req.start_index = '0;
		req.last_index = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_checks();

		// receiver holds off while requests keep coming
		hold_off_left = 400;
		run_random(157);

		sender_idle_pct = 83;
		receiver_stall_pct = 0;
		run_random(157);

		sender_idle_pct = 0;
		receiver_stall_pct = 83;
		run_random(157);

		sender_idle_pct = 9;
		receiver_stall_pct = 9;
		run_random(157);

		req.valid <= 1'b0;
		while (sb.pending_responses.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d requests: %0d writes, %0d sifts, %0d reads, %0d of the unused kind",
			sb.checked, sb.kind_count[K_WRITE], sb.kind_count[K_SIFT], sb.kind_count[K_READ],
			sb.kind_count[KIND_UNUSED]);
		$display("deepest sift moved %0d levels, longest input stall %0d cycles",
			sb.deepest_sift, longest_stall);
		if (sb.failures == 0 && sb.pending_responses.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* heap_sift_down_unit.f */
+incdir+sv
sv/hsd_pkg.sv
sv/hsd_if.sv
sv/hsd_ram.sv
sv/heap_sift_down_unit.sv
tb/sv/heap_sift_down_unit_test.sv
